// File: hdl/kwm_pkg.sv
// Shared types, widths and codes of the k-way timestamp merge.
package kwm_pkg;

   localparam int STREAMS_DEFAULT = 8;
   localparam int EVENTS_DEFAULT = 256;
   localparam int STAMP_BITS_DEFAULT = 64;

   localparam int STREAM_FIELD_BITS = 3;
   localparam int STAMP_FIELD_BITS = 64;
   localparam int PAYLOAD_BITS = 16;
   localparam int POSITION_BITS = 8;
   localparam int STATUS_BITS = 2;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_TAKE = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_STORED = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_TAKEN = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_DRAINED = 2'd3;

   typedef struct packed {
      logic                         command;
      logic [STREAM_FIELD_BITS-1:0] stream;
      logic [STAMP_FIELD_BITS-1:0]  stamp;
      logic [PAYLOAD_BITS-1:0]      payload;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]       status;
      logic [STREAM_FIELD_BITS-1:0] from_stream;
      logic [POSITION_BITS-1:0]     position;
      logic [STAMP_FIELD_BITS-1:0]  out_stamp;
      logic [PAYLOAD_BITS-1:0]      out_payload;
   } rsp_item_type;

endpackage

// File: hdl/k_way_timestamp_merge.sv
// Top level of the k-way timestamp merge: per-stream event lists and earliest-head selection.
//
// An append is taken in the same cycle as start and its status appears with rsp_strobe in the
// cycle after the transfer, with busy staying low, so appends can arrive every cycle. A take
// holds busy through the scan, last and finish states, and its result is registered out of the
// finish state: the head of each stream is read from the event memory through its single read
// port, one stream per cycle, and compared against the best head so far. Each result is shown
// for exactly one cycle and the receiver cannot stall it. Appends with out-of-range stream
// numbers are answered as full. The event memory needs no clearing after reset.
module k_way_timestamp_merge #(
   parameter int STREAMS = kwm_pkg::STREAMS_DEFAULT,
   parameter int EVENTS_PER_STREAM = kwm_pkg::EVENTS_DEFAULT,
   parameter int STAMP_BITS = kwm_pkg::STAMP_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  kwm_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output kwm_pkg::rsp_item_type rsp_item
);
   import kwm_pkg::*;

   localparam int SW = $clog2(STREAMS);
   localparam int IW = $clog2(EVENTS_PER_STREAM);
   localparam int CW = $clog2(EVENTS_PER_STREAM + 1);
   localparam int AW = SW + IW;
   localparam int DEPTH = STREAMS * (2 ** IW);
   localparam int MW = STAMP_BITS + PAYLOAD_BITS;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_LAST = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [SW-1:0]         scan_ff, scan_in;
   logic [CW-1:0]         fill_ff [STREAMS];
   logic [CW-1:0]         fill_in [STREAMS];
   logic [CW-1:0]         cursor_ff [STREAMS];
   logic [CW-1:0]         cursor_in [STREAMS];
   logic                  pend_valid_ff, pend_valid_in;
   logic                  pend_live_ff, pend_live_in;
   logic [SW-1:0]         pend_stream_ff, pend_stream_in;
   logic [CW-1:0]         pend_pos_ff, pend_pos_in;
   logic                  found_ff, found_in;
   logic [SW-1:0]         best_stream_ff, best_stream_in;
   logic [CW-1:0]         best_pos_ff, best_pos_in;
   logic [STAMP_BITS-1:0] best_stamp_ff, best_stamp_in;
   logic [PAYLOAD_BITS-1:0] best_payload_ff, best_payload_in;
   rsp_item_type          rsp_ff, rsp_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   logic                  accept;
   logic [SW-1:0]         idx;
   logic [CW-1:0]         fill_rd;
   logic [CW-1:0]         cur_rd;
   logic                  stream_ok;
   logic                  room;
   logic                  do_append;
   logic                  better;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [MW-1:0]         wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [MW-1:0]         rd_data;
   logic [STAMP_BITS-1:0] rd_stamp;
   logic [PAYLOAD_BITS-1:0] rd_payload;

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign idx = (state_ff == S_SCAN) ? scan_ff : SW'(req_item.stream);
   assign fill_rd = fill_ff[idx];
   assign cur_rd = cursor_ff[idx];
   assign stream_ok = 32'(req_item.stream) < 32'(STREAMS);
   assign room = fill_rd < CW'(EVENTS_PER_STREAM);
   assign do_append = accept && (req_item.command == CMD_APPEND) && stream_ok && room;

   assign wr_en = do_append;
   assign wr_addr = {idx, fill_rd[IW-1:0]};
   assign wr_data = {req_item.stamp[STAMP_BITS-1:0], req_item.payload};
   assign rd_en = (state_ff == S_SCAN);
   assign rd_addr = {scan_ff, cur_rd[IW-1:0]};
   assign rd_stamp = rd_data[MW-1:PAYLOAD_BITS];
   assign rd_payload = rd_data[PAYLOAD_BITS-1:0];

   assign better = pend_valid_ff && pend_live_ff && (!found_ff || (rd_stamp < best_stamp_ff));

   kwm_ram #(
      .WIDTH (MW),
      .DEPTH (DEPTH)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      scan_in = scan_ff;
      fill_in = fill_ff;
      cursor_in = cursor_ff;
      pend_valid_in = 1'b0;
      pend_live_in = cur_rd < fill_rd;
      pend_stream_in = scan_ff;
      pend_pos_in = cur_rd;
      found_in = found_ff;
      best_stream_in = best_stream_ff;
      best_pos_in = best_pos_ff;
      best_stamp_in = best_stamp_ff;
      best_payload_in = best_payload_ff;
      rsp_in = rsp_ff;
      rsp_strobe_in = 1'b0;

      if (better) begin
         found_in = 1'b1;
         best_stream_in = pend_stream_ff;
         best_pos_in = pend_pos_ff;
         best_stamp_in = rd_stamp;
         best_payload_in = rd_payload;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_item.command == CMD_TAKE) begin
                  state_in = S_SCAN;
                  scan_in = '0;
                  found_in = 1'b0;
               end else begin
                  rsp_in = '0;
                  rsp_in.status = do_append ? ST_STORED : ST_FULL;
                  rsp_strobe_in = 1'b1;
                  if (do_append) begin
                     fill_in[idx] = CW'(fill_rd + 1'b1);
                  end
               end
            end
         end
         S_SCAN: begin
            pend_valid_in = 1'b1;
            if (scan_ff == SW'(STREAMS - 1)) begin
               state_in = S_LAST;
            end else begin
               scan_in = SW'(scan_ff + 1'b1);
            end
         end
         S_LAST: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            rsp_in = '0;
            rsp_strobe_in = 1'b1;
            state_in = S_IDLE;
            if (found_ff) begin
               rsp_in.status = ST_TAKEN;
               rsp_in.from_stream = STREAM_FIELD_BITS'(best_stream_ff);
               rsp_in.position = POSITION_BITS'(best_pos_ff);
               rsp_in.out_stamp = STAMP_FIELD_BITS'(best_stamp_ff);
               rsp_in.out_payload = best_payload_ff;
               cursor_in[best_stream_ff] = CW'(best_pos_ff + 1'b1);
            end else begin
               rsp_in.status = ST_DRAINED;
               for (int i = 0; i < STREAMS; i++) begin
                  fill_in[i] = '0;
                  cursor_in[i] = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scan_ff <= '0;
         pend_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < STREAMS; i++) begin
            fill_ff[i] <= '0;
            cursor_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         scan_ff <= scan_in;
         pend_valid_ff <= pend_valid_in;
         found_ff <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
         fill_ff <= fill_in;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_live_ff <= pend_live_in;
      pend_stream_ff <= pend_stream_in;
      pend_pos_ff <= pend_pos_in;
      best_stream_ff <= best_stream_in;
      best_pos_ff <= best_pos_in;
      best_stamp_ff <= best_stamp_in;
      best_payload_ff <= best_payload_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_ff;

endmodule

// File: hdl/kwm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module kwm_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/kwm_checker.sv
// Port-level checker for the k-way timestamp merge, bound to the top level.
module kwm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input kwm_pkg::req_item_type req_item,
   input logic                  rsp_strobe,
   input kwm_pkg::rsp_item_type rsp_item
);
   import kwm_pkg::*;

   a_append_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.command == CMD_APPEND) |=>
         (rsp_strobe && (rsp_item.status == ST_STORED || rsp_item.status == ST_FULL)))
      else $error("An append transfer was not answered with a store status.");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.command == CMD_TAKE) |=> (busy && !rsp_strobe))
      else $error("A take transfer did not hold the block busy.");

   a_take_done: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |->
         (rsp_strobe && (rsp_item.status == ST_TAKEN || rsp_item.status == ST_DRAINED)))
      else $error("A take finished without a take status.");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != ST_TAKEN) |->
         (rsp_item.from_stream == '0 && rsp_item.position == '0 &&
          rsp_item.out_stamp == '0 && rsp_item.out_payload == '0))
      else $error("A result without a taken event carried non-zero fields.");

endmodule

bind k_way_timestamp_merge kwm_checker u_kwm_checker (.*);
